// ===== hw/rtl/hesd_pkg.sv =====
// Package for the HTML entity stream decoder: state codes, character constants,
// numeric limits and the named-reference table.
// No dependencies.
package hesd_pkg;

    localparam int SEMI_SEARCH_SPAN_DEF = 32;
    localparam int NAME_MAX_LEN         = 6;
    localparam int NAME_COUNT           = 126;
    localparam int CP_W                 = 21;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] UTF8_MAX1   = 21'h00007F;
    localparam logic [CP_W-1:0] UTF8_MAX2   = 21'h0007FF;
    localparam logic [CP_W-1:0] UTF8_MAX3   = 21'h00FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_DAT,
        ST_EMIT,
        ST_FIN
    } hesd_state_t;

    localparam logic [47:0] NAME_STR [NAME_COUNT] = '{
        "amp", "lt", "gt", "quot", "apos",
        "nbsp", "copy", "reg", "trade",
        "mdash", "ndash", "laquo", "raquo",
        "lsquo", "rsquo", "ldquo", "rdquo",
        "bull", "hellip", "middot", "para",
        "sect", "deg", "plusmn", "times",
        "divide", "frac12", "frac14", "frac34",
        "iexcl", "iquest", "cent", "pound",
        "curren", "yen", "euro", "eacute",
        "egrave", "ecirc", "aacute", "agrave",
        "acirc", "uuml", "uacute", "ugrave",
        "ouml", "oacute", "ograve", "ocirc",
        "oslash", "auml", "iuml", "aring",
        "aelig", "ccedil", "ntilde", "szlig",
        "Agrave", "Aacute", "Acirc", "Auml",
        "Aring", "AElig", "Egrave", "Eacute",
        "Ecirc", "Igrave", "Iacute", "Ograve",
        "Oacute", "Ocirc", "Ouml", "Oslash",
        "Ugrave", "Uacute", "Uuml", "THORN",
        "thorn", "ETH", "eth", "Yacute",
        "yacute", "yuml",
        "larr", "uarr", "rarr", "darr",
        "harr", "lArr", "uArr", "rArr",
        "dArr", "hArr", "spades", "clubs",
        "hearts", "diams", "loz", "ensp",
        "emsp", "thinsp", "zwnj", "zwj",
        "lrm", "rlm", "shy", "macr",
        "acute", "micro", "ordf", "ordm",
        "sup1", "sup2", "sup3", "not",
        "brvbar", "cedil", "uml", "circ",
        "tilde", "ring", "dagger", "Dagger",
        "permil", "lsaquo", "rsaquo"
    };

    localparam logic [CP_W-1:0] NAME_CP [NAME_COUNT] = '{
        21'h26, 21'h3C, 21'h3E, 21'h22, 21'h27,
        21'hA0, 21'hA9, 21'hAE, 21'h2122,
        21'h2014, 21'h2013, 21'hAB, 21'hBB,
        21'h2018, 21'h2019, 21'h201C, 21'h201D,
        21'h2022, 21'h2026, 21'hB7, 21'hB6,
        21'hA7, 21'hB0, 21'hB1, 21'hD7,
        21'hF7, 21'hBD, 21'hBC, 21'hBE,
        21'hA1, 21'hBF, 21'hA2, 21'hA3,
        21'hA4, 21'hA5, 21'h20AC, 21'hE9,
        21'hE8, 21'hEA, 21'hE1, 21'hE0,
        21'hE2, 21'hFC, 21'hFA, 21'hF9,
        21'hF6, 21'hF3, 21'hF2, 21'hF4,
        21'hF8, 21'hE4, 21'hEF, 21'hE5,
        21'hE6, 21'hE7, 21'hF1, 21'hDF,
        21'hC0, 21'hC1, 21'hC2, 21'hC4,
        21'hC5, 21'hC6, 21'hC8, 21'hC9,
        21'hCA, 21'hCC, 21'hCD, 21'hD2,
        21'hD3, 21'hD4, 21'hD6, 21'hD8,
        21'hD9, 21'hDA, 21'hDC, 21'hDE,
        21'hFE, 21'hD0, 21'hF0, 21'hDD,
        21'hFD, 21'hFF,
        21'h2190, 21'h2191, 21'h2192, 21'h2193,
        21'h2194, 21'h21D0, 21'h21D1, 21'h21D2,
        21'h21D3, 21'h21D4, 21'h2660, 21'h2663,
        21'h2665, 21'h2666, 21'h25CA, 21'h2002,
        21'h2003, 21'h2009, 21'h200C, 21'h200D,
        21'h200E, 21'h200F, 21'hAD, 21'hAF,
        21'hB4, 21'hB5, 21'hAA, 21'hBA,
        21'hB9, 21'hB2, 21'hB3, 21'hAC,
        21'hA6, 21'hB8, 21'hA8, 21'h2C6,
        21'h2DC, 21'h2DA, 21'h2020, 21'h2021,
        21'h2030, 21'h2039, 21'h203A
    };

    function automatic logic [2:0] name_len(input int idx);
        logic [2:0] n;
        n = 3'd0;
        for (int b = 0; b < NAME_MAX_LEN; b++) begin
            if (NAME_STR[idx][8*b +: 8] != 8'h00) n = 3'(b + 1);
        end
        return n;
    endfunction

    // character j of name idx, counted from the start of the name; zero past its end
    function automatic logic [7:0] name_char(input int idx, input logic [2:0] j);
        int len;
        len = int'(name_len(idx));
        if (int'(j) >= len) return 8'h00;
        return NAME_STR[idx][8*(len - 1 - int'(j)) +: 8];
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

// ===== hw/rtl/hesd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module hesd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/html_entity_stream_decoder_core.sv =====
// Top level of the HTML entity stream decoder: sequencer, scan state and output stage.
// Depends on hesd_pkg and hesd_ram.
//
// Bytes stream in on s_ and decoded UTF-8 leaves on m_. Plain bytes pass through;
// an '&' opens a window of up to SEMI_SEARCH_SPAN more bytes, kept in a ring RAM,
// that is replaced by the UTF-8 of its numeric or named reference once decided.
// One word is taken at a time: no new input word is accepted until the last
// one is settled, and a decided reference has the rest of its window rescanned.
// The sequencer walks the window through the single RAM read port one byte at
// a time. m_tlast marks the last output word caused by one input word;
// m_tuser marks the final word of a text (the one whose input had s_tlast).
module html_entity_stream_decoder_core
    import hesd_pkg::*;
#(
    parameter int SEMI_SEARCH_SPAN = SEMI_SEARCH_SPAN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // out_run_last
    output logic       m_tuser    // [0] out_text_end
);

    localparam int WIN_DEPTH = SEMI_SEARCH_SPAN + 1;
    localparam int PW        = $clog2(WIN_DEPTH);
    localparam int RAM_DEPTH = 1 << PW;
    localparam int FW        = $clog2(WIN_DEPTH + 1);

    hesd_state_t state_reg, state_next;

    logic [PW-1:0]     head_reg, head_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              end_reg, end_next;
    logic              scan_reg, scan_next;
    logic [FW-1:0]     k_reg, k_next;
    logic              num_reg, num_next;
    logic              hex_reg, hex_next;
    logic              bad_reg, bad_next;
    logic              dig_reg, dig_next;
    logic [CP_W-1:0]   val_reg, val_next;
    logic [NAME_COUNT-1:0] mask_reg, mask_next;
    logic              alpha_reg, alpha_next;
    logic              hit_reg, hit_next;
    logic [CP_W-1:0]   hit_cp_reg, hit_cp_next;
    logic              best_reg, best_next;
    logic [CP_W-1:0]   best_cp_reg, best_cp_next;
    logic [2:0]        best_len_reg, best_len_next;
    logic [CP_W-1:0]   ecp_reg, ecp_next;
    logic              raw_reg, raw_next;
    logic [2:0]        nb_reg, nb_next;
    logic [1:0]        bi_reg, bi_next;
    logic [FW-1:0]     drop_reg, drop_next;
    logic              pend_reg, pend_next;
    logic [7:0]        pend_byte_reg, pend_byte_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              ram_wr_en, ram_rd_en;
    logic [PW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [7:0]        ram_rd_data;

    hesd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_win_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // scan datapath for the byte at window offset k
    logic [7:0]        c;
    logic [FW-1:0]     j;
    logic              c_dec, c_hex;
    logic [3:0]        d;
    logic [24:0]       prod;
    logic [NAME_COUNT-1:0] mask_upd;
    logic              hit_upd;
    logic [CP_W-1:0]   hit_cp_upd;
    logic              semi_ok;
    logic [CP_W-1:0]   semi_cp;
    logic              out_free;
    logic [7:0]        ebyte;
    logic [2:0]        nb_of_cp;

    assign c = ram_rd_data;
    assign j = k_reg - FW'(1);
    assign c_dec = (c >= 8'h30 && c <= 8'h39);
    assign c_hex = c_dec || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);

    always_comb begin
        if (c_dec)                      d = c[3:0];
        else if (c >= 8'h61)            d = 4'(c - 8'h57);
        else                            d = 4'(c - 8'h37);
        if (hex_reg) prod = {val_reg, 4'b0} + 25'(d);
        else         prod = 25'({val_reg, 3'b0}) + 25'({val_reg, 1'b0}) + 25'(d);
    end

    always_comb begin
        hit_upd    = 1'b0;
        hit_cp_upd = '0;
        for (int i = 0; i < NAME_COUNT; i++) begin
            mask_upd[i] = mask_reg[i] && (j < FW'(NAME_MAX_LEN))
                          && (name_char(i, j[2:0]) == c);
        end
        // lowest index wins
        for (int i = NAME_COUNT - 1; i >= 0; i--) begin
            if (mask_upd[i] && FW'(name_len(i)) == k_reg) begin
                hit_upd    = 1'b1;
                hit_cp_upd = NAME_CP[i];
            end
        end
    end

    always_comb begin
        if (num_reg) begin
            semi_ok = !bad_reg && dig_reg && val_reg != '0
                      && !(val_reg >= SURR_LO && val_reg <= SURR_HI);
            semi_cp = val_reg;
        end else begin
            semi_ok = hit_reg;
            semi_cp = hit_cp_reg;
        end
        if (k_reg == FW'(1)) semi_ok = 1'b0;   // empty body
    end

    always_comb begin
        if (ecp_next <= UTF8_MAX1)      nb_of_cp = 3'd1;
        else if (ecp_next <= UTF8_MAX2) nb_of_cp = 3'd2;
        else if (ecp_next <= UTF8_MAX3) nb_of_cp = 3'd3;
        else                            nb_of_cp = 3'd4;
    end

    always_comb begin
        ebyte = ecp_reg[7:0];
        if (!raw_reg) begin
            unique case (nb_reg)
                3'd2: ebyte = (bi_reg == 2'd0) ? {3'b110, ecp_reg[10:6]}
                                               : {2'b10, ecp_reg[5:0]};
                3'd3: begin
                    unique case (bi_reg)
                        2'd0:    ebyte = {4'b1110, ecp_reg[15:12]};
                        2'd1:    ebyte = {2'b10, ecp_reg[11:6]};
                        default: ebyte = {2'b10, ecp_reg[5:0]};
                    endcase
                end
                3'd4: begin
                    unique case (bi_reg)
                        2'd0: ebyte = {5'b11110, ecp_reg[20:18]};
                        2'd1: ebyte = {2'b10, ecp_reg[17:12]};
                        2'd2: ebyte = {2'b10, ecp_reg[11:6]};
                        2'd3: ebyte = {2'b10, ecp_reg[5:0]};
                    endcase
                end
                default: ebyte = ecp_reg[7:0];
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            scan_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        end_reg       <= end_next;
        k_reg         <= k_next;
        num_reg       <= num_next;
        hex_reg       <= hex_next;
        bad_reg       <= bad_next;
        dig_reg       <= dig_next;
        val_reg       <= val_next;
        mask_reg      <= mask_next;
        alpha_reg     <= alpha_next;
        hit_reg       <= hit_next;
        hit_cp_reg    <= hit_cp_next;
        best_reg      <= best_next;
        best_cp_reg   <= best_cp_next;
        best_len_reg  <= best_len_next;
        ecp_reg       <= ecp_next;
        raw_reg       <= raw_next;
        nb_reg        <= nb_next;
        bi_reg        <= bi_next;
        drop_reg      <= drop_next;
        pend_byte_reg <= pend_byte_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
        m_tuser_reg   <= m_tuser_next;
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        end_next       = end_reg;
        scan_next      = scan_reg;
        k_next         = k_reg;
        num_next       = num_reg;
        hex_next       = hex_reg;
        bad_next       = bad_reg;
        dig_next       = dig_reg;
        val_next       = val_reg;
        mask_next      = mask_reg;
        alpha_next     = alpha_reg;
        hit_next       = hit_reg;
        hit_cp_next    = hit_cp_reg;
        best_next      = best_reg;
        best_cp_next   = best_cp_reg;
        best_len_next  = best_len_reg;
        ecp_next       = ecp_reg;
        raw_next       = raw_reg;
        nb_next        = nb_reg;
        bi_next        = bi_reg;
        drop_next      = drop_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = head_reg + fill_reg[PW-1:0];
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg ? head_reg + k_reg[PW-1:0] : head_reg;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    end_next = s_tlast;
                    if (fill_reg < FW'(WIN_DEPTH)) begin
                        ram_wr_en = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = ST_RD;
                end
            end

            ST_RD: begin
                if (fill_reg == '0) begin
                    state_next = ST_FIN;
                end else if (scan_reg && k_reg == fill_reg) begin
                    // no ';' in the window: once it is full or the text ends, decide by longest name prefix
                    if (fill_reg == FW'(WIN_DEPTH) || end_reg) begin
                        raw_next = 1'b0;
                        bi_next  = '0;
                        if (best_reg) begin
                            ecp_next  = best_cp_reg;
                            drop_next = FW'(best_len_reg) + FW'(1);
                        end else begin
                            ecp_next  = CP_W'(CH_AMP);
                            drop_next = FW'(1);
                        end
                        nb_next    = nb_of_cp;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FIN;
                    end
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_DAT;
                end
            end

            ST_DAT: begin
                state_next = ST_RD;
                if (!scan_reg) begin
                    if (c == CH_AMP) begin
                        scan_next  = 1'b1;
                        k_next     = FW'(1);
                        mask_next  = '1;
                        alpha_next = 1'b1;
                        hit_next   = 1'b0;
                        best_next  = 1'b0;
                        num_next   = 1'b0;
                    end else begin
                        ecp_next   = CP_W'(c);
                        raw_next   = 1'b1;
                        nb_next    = 3'd1;
                        bi_next    = '0;
                        drop_next  = FW'(1);
                        state_next = ST_EMIT;
                    end
                end else if (c == CH_SEMI) begin
                    raw_next = 1'b0;
                    bi_next  = '0;
                    if (semi_ok) begin
                        ecp_next  = semi_cp;
                        drop_next = k_reg + FW'(1);
                    end else begin
                        ecp_next  = CP_W'(CH_AMP);
                        drop_next = FW'(1);
                    end
                    nb_next    = nb_of_cp;
                    state_next = ST_EMIT;
                end else begin
                    if (j == '0) begin
                        num_next = (c == CH_HASH);
                        hex_next = 1'b0;
                        bad_next = 1'b0;
                        dig_next = 1'b0;
                        val_next = '0;
                    end else if (num_reg) begin
                        if (j == FW'(1) && (c == 8'h78 || c == 8'h58)) begin
                            hex_next = 1'b1;
                        end else if (!(hex_reg ? c_hex : c_dec)) begin
                            bad_next = 1'b1;
                        end else begin
                            dig_next = 1'b1;
                            if (!bad_reg) begin
                                if (prod > 25'(CP_MAX)) bad_next = 1'b1;
                                else                    val_next = CP_W'(prod);
                            end
                        end
                    end
                    mask_next   = mask_upd;
                    alpha_next  = alpha_reg && is_letter(c);
                    hit_next    = hit_upd;
                    hit_cp_next = hit_cp_upd;
                    if (alpha_reg && is_letter(c) && hit_upd) begin
                        best_next     = 1'b1;
                        best_cp_next  = hit_cp_upd;
                        best_len_next = k_reg[2:0];
                    end
                    k_next = k_reg + FW'(1);
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    if (pend_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pend_byte_reg;
                        m_tlast_next  = 1'b0;
                        m_tuser_next  = 1'b0;
                    end
                    pend_next      = 1'b1;
                    pend_byte_next = ebyte;
                    bi_next        = bi_reg + 2'd1;
                    if (3'(bi_reg) + 3'd1 == nb_reg) begin
                        head_next  = head_reg + drop_reg[PW-1:0];
                        fill_next  = fill_reg - drop_reg;
                        scan_next  = 1'b0;
                        state_next = ST_RD;
                    end
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    if (pend_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pend_byte_reg;
                        m_tlast_next  = 1'b1;
                        m_tuser_next  = end_reg;
                    end
                    pend_next = 1'b0;
                    if (end_reg) begin
                        fill_next = '0;
                        scan_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(WIN_DEPTH))
        else $error("window fill above depth");

    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> fill_reg < FW'(WIN_DEPTH) && !pend_reg)
        else $error("idle with full window or unflushed word");

    a_scan_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_reg |-> k_reg <= fill_reg && k_reg != '0)
        else $error("scan offset outside window");

    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free && end_reg |=> fill_reg == '0 && m_tvalid_reg)
        else $error("text end left data behind");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for html_entity_stream_decoder_core: streams text words in,
// predicts the decoded UTF-8 words and checks them on the master side.
// Depends on hesd_pkg (name table, character codes) and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import hesd_pkg::*;

    localparam int WIN_DEPTH   = SEMI_SEARCH_SPAN_DEF + 1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_WORDS  = 370;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } out_word_t;

    typedef struct {
        string      text;
        int         n_out;   // words caused by the final input word
        logic [7:0] first;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    html_entity_stream_decoder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [7:0] win_bytes [WIN_DEPTH];
    int         win_fill = 0;
    logic [7:0] step_bytes [$];
    out_word_t  decoded_q [$];

    int  fails = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    bit  drained = 1'b0;
    int  words_sent = 0;

    function automatic int unsigned lookup_name(int start, int n);
        logic [47:0] key;
        key = '0;
        if (n == 0 || n > NAME_MAX_LEN) return 0;
        for (int k = 0; k < n; k++) key = {key[39:0], win_bytes[start + k]};
        for (int i = 0; i < NAME_COUNT; i++)
            if (NAME_STR[i] == key) return NAME_CP[i];
        return 0;
    endfunction

    function automatic int digit_val(logic [7:0] c, bit hex);
        if (c >= "0" && c <= "9") return c - "0";
        if (hex && c >= "a" && c <= "f") return c - "a" + 10;
        if (hex && c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // body is win_bytes[1 .. n]; 0 means the reference fails
    function automatic int unsigned body_cp(int n);
        bit hex;
        int first, d;
        int unsigned cp;
        cp = 0;
        if (n == 0) return 0;
        if (win_bytes[1] != CH_HASH) return lookup_name(1, n);
        hex = n > 1 && (win_bytes[2] == "x" || win_bytes[2] == "X");
        first = hex ? 2 : 1;
        if (first >= n) return 0;
        for (int i = first; i < n; i++) begin
            d = digit_val(win_bytes[1 + i], hex);
            if (d < 0) return 0;
            cp = cp * (hex ? 16 : 10) + d;
            if (cp > CP_MAX) return 0;
        end
        if (cp == 0 || (cp >= SURR_LO && cp <= SURR_HI)) return 0;
        return cp;
    endfunction

    function automatic void put_utf8(int unsigned cp);
        if (cp <= UTF8_MAX1) begin
            step_bytes.push_back(cp[7:0]);
        end else if (cp <= UTF8_MAX2) begin
            step_bytes.push_back(8'hC0 | cp[10:6]);
            step_bytes.push_back(8'h80 | cp[5:0]);
        end else if (cp <= UTF8_MAX3) begin
            step_bytes.push_back(8'hE0 | cp[15:12]);
            step_bytes.push_back(8'h80 | cp[11:6]);
            step_bytes.push_back(8'h80 | cp[5:0]);
        end else begin
            step_bytes.push_back(8'hF0 | cp[20:18]);
            step_bytes.push_back(8'h80 | cp[17:12]);
            step_bytes.push_back(8'h80 | cp[11:6]);
            step_bytes.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic void drop_front(int k);
        if (k > win_fill) k = win_fill;
        for (int i = 0; i + k < win_fill; i++) win_bytes[i] = win_bytes[i + k];
        win_fill -= k;
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void settle_window(bit at_end);
        int semi, run, len;
        int unsigned cp;
        while (win_fill > 0) begin
            if (win_bytes[0] != CH_AMP) begin
                step_bytes.push_back(win_bytes[0]);
                drop_front(1);
                continue;
            end
            semi = 0;
            for (int k = 1; k < win_fill && k <= SEMI_SEARCH_SPAN_DEF; k++)
                if (win_bytes[k] == CH_SEMI) begin
                    semi = k;
                    break;
                end
            if (semi != 0) begin
                cp = body_cp(semi - 1);
                if (cp != 0) begin
                    put_utf8(cp);
                    drop_front(semi + 1);
                end else begin
                    step_bytes.push_back(CH_AMP);
                    drop_front(1);
                end
                continue;
            end
            if (win_fill < WIN_DEPTH && !at_end) break;
            // no ';': longest table name prefixing the letter run
            run = 0;
            while (1 + run < win_fill && letter(win_bytes[1 + run])) run++;
            len = run < NAME_MAX_LEN ? run : NAME_MAX_LEN;
            cp = 0;
            for (; len > 0; len--) begin
                cp = lookup_name(1, len);
                if (cp != 0) break;
            end
            if (cp != 0) begin
                put_utf8(cp);
                drop_front(1 + len);
            end else begin
                step_bytes.push_back(CH_AMP);
                drop_front(1);
            end
        end
    endfunction

    // returns the number of words this input word causes
    function automatic int decode_word(logic [7:0] b, bit text_end);
        out_word_t w;
        int n;
        step_bytes.delete();
        if (win_fill < WIN_DEPTH) begin
            win_bytes[win_fill] = b;
            win_fill++;
        end
        settle_window(text_end);
        if (text_end) win_fill = 0;
        n = step_bytes.size();
        for (int i = 0; i < n; i++) begin
            w.data = step_bytes[i];
            w.run_last = (i == n - 1);
            w.text_end = (i == n - 1) && text_end;
            decoded_q.push_back(w);
        end
        return n;
    endfunction

    // sender: drive at falling edge, accept at rising edge
    task automatic send_word(logic [7:0] b, bit text_end, output int n_out);
        while (!no_idle && $urandom_range(99) < 11) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = text_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_out = decode_word(b, text_end);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(logic [7:0] txt [$]);
        int n;
        foreach (txt[i]) send_word(txt[i], i == txt.size() - 1, n);
    endtask

    function automatic void add_str(ref logic [7:0] txt [$], input string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    // one random reference, well formed or broken
    function automatic void add_ref(ref logic [7:0] txt [$]);
        int idx, len, pick;
        int unsigned v;
        pick = $urandom_range(9);
        txt.push_back(CH_AMP);
        if (pick < 4) begin
            idx = $urandom_range(NAME_COUNT - 1);
            len = 0;
            for (int b = NAME_MAX_LEN - 1; b >= 0; b--)
                if (NAME_STR[idx][8*b +: 8] != 8'h00) txt.push_back(NAME_STR[idx][8*b +: 8]);
            if (pick != 3) txt.push_back(CH_SEMI);
            else if ($urandom_range(1)) add_str(txt, "zq");
        end else if (pick < 7) begin
            case ($urandom_range(4))
                0: v = $urandom_range(127);
                1: v = $urandom_range(32'h7FF);
                2: v = $urandom_range(32'hFFFF);
                3: v = $urandom_range(32'h10FFFF);
                default: v = $urandom_range(32'hDFFF, 32'hD800) + $urandom_range(1) * 32'h110000;
            endcase
            txt.push_back(CH_HASH);
            if (pick == 4) begin
                add_str(txt, $sformatf("%0d", v));
            end else begin
                txt.push_back($urandom_range(1) ? "x" : "X");
                add_str(txt, $sformatf("%0h", v));
            end
            txt.push_back(CH_SEMI);
        end else if (pick == 7) begin
            // long run without ';' that can overflow the window
            len = $urandom_range(40, 28);
            repeat (len) txt.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25)) : "#");
        end else begin
            len = $urandom_range(6);
            repeat (len) txt.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) txt.push_back(CH_SEMI);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("out_byte: unexpected word %h", m_tdata);
                fails++;
            end else begin
                exp_w = decoded_q.pop_front();
                if (m_tdata !== exp_w.data) begin
                    $error("out_byte: expected %h, got %h", exp_w.data, m_tdata);
                    fails++;
                end
                if (m_tlast !== exp_w.run_last) begin
                    $error("out_run_last: expected %b, got %b", exp_w.run_last, m_tlast);
                    fails++;
                end
                if (m_tuser !== exp_w.text_end) begin
                    $error("out_text_end: expected %b, got %b", exp_w.text_end, m_tuser);
                    fails++;
                end
            end
        end
    end

    always @(negedge aclk)
        m_tready <= no_idle || ($urandom_range(99) >= 11);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    dir_row_t dir_rows [6] = '{
        '{"&;",         2, 8'h26},
        '{"&#1;",       1, 8'h01},
        '{"&#X10FFFF;", 4, 8'hF4},
        '{"&#;",        3, 8'h26},
        '{"&not\xff",   3, 8'hC2},
        '{"\x00",       1, 8'h00}
    };

    initial begin
        logic [7:0] txt [$];
        logic [7:0] got_first;
        int n;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            txt.delete();
            add_str(txt, dir_rows[r].text);
            if (dir_rows[r].text.len() == 0) txt.push_back(8'h00);
            for (int i = 0; i < txt.size(); i++) begin
                send_word(txt[i], i == txt.size() - 1, n);
            end
            // this word's results sit at the tail of the queue until they leave
            got_first = (n > 0) ? decoded_q[decoded_q.size() - n].data : 8'h00;
            if (n != dir_rows[r].n_out || got_first !== dir_rows[r].first) begin
                $error("out_byte: row %0d expected %0d words from %h, predicted %0d from %h",
                       r, dir_rows[r].n_out, dir_rows[r].first, n, got_first);
                fails++;
            end
        end

        words_sent = 0;
        while (words_sent < RAND_WORDS) begin
            no_idle = words_sent > 150 && words_sent < 230;
            if (!drained && words_sent > 100) begin
                // hold off until the block has drained
                drained = 1'b1;
                s_tvalid = 1'b0;
                while (decoded_q.size() != 0) @(negedge aclk);
            end
            txt.delete();
            repeat ($urandom_range(6, 1)) begin
                if ($urandom_range(3) == 0) repeat ($urandom_range(4, 1))
                    txt.push_back(8'($urandom_range(255)));
                else add_ref(txt);
            end
            send_text(txt);
        end
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        no_idle = 1'b0;

        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fails == 0 && decoded_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
